### sv/hcb_pkg.sv
// ============================================================================
// hcb_pkg: shared constants for the Huffman code builder
// Field widths and the default capacity of the builder.
// ============================================================================
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int SYM_W           = 8;
    localparam int FREQ_W          = 16;
    localparam int WEIGHT_W        = 20;
    localparam int LEN_W           = 4;
    localparam int CODE_W          = 15;

endpackage

### sv/hcb_ram.sv
// ============================================================================
// hcb_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ============================================================================
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hcb_scan_unit.sv
// ============================================================================
// hcb_scan_unit: running two-minimum tracker
// Takes one slot weight per step and keeps the lightest and second lightest.
// ============================================================================
module hcb_scan_unit #(
    parameter int SW = 4,
    parameter int NW = 5
) (
    input  logic                         i_clk,
    input  logic                         i_step,
    input  logic [SW-1:0]                i_pos,
    input  logic [NW-1:0]                i_node,
    input  logic [hcb_pkg::WEIGHT_W-1:0] i_weight,
    output logic [SW-1:0]                o_slot_a,
    output logic [SW-1:0]                o_slot_b,
    output logic [NW-1:0]                o_node_a,
    output logic [NW-1:0]                o_node_b,
    output logic [hcb_pkg::WEIGHT_W-1:0] o_weight_sum
);

    logic [SW-1:0]                r_sa, r_sb;
    logic [NW-1:0]                r_na, r_nb;
    logic [hcb_pkg::WEIGHT_W-1:0] r_wa, r_wb;
    logic                         lt_a, lt_b, first, second;

    assign first  = (i_pos == SW'(0));
    assign second = (i_pos == SW'(1));
    assign lt_a   = (i_weight < r_wa);
    assign lt_b   = (i_weight < r_wb);

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (first) begin
                r_sa <= i_pos; r_na <= i_node; r_wa <= i_weight;
            end else if (lt_a) begin
                // new lightest; old lightest drops to second
                r_sb <= r_sa; r_nb <= r_na; r_wb <= r_wa;
                r_sa <= i_pos; r_na <= i_node; r_wa <= i_weight;
            end else if (second || lt_b) begin
                r_sb <= i_pos; r_nb <= i_node; r_wb <= i_weight;
            end
        end
    end

    assign o_slot_a     = r_sa;
    assign o_slot_b     = r_sb;
    assign o_node_a     = r_na;
    assign o_node_b     = r_nb;
    assign o_weight_sum = r_wa + r_wb;

endmodule

### sv/huffman_code_builder.sv
// ============================================================================
// huffman_code_builder: Huffman tree build and code emission
// Loads leaves, merges under a sequencer, walks the tree and emits codes.
// ============================================================================
// Symbols load one transaction per cycle. The transaction with last set
// stalls the input while the tree is built and codes are emitted. With n
// leaves the build first writes an identity slot list of n entries, then
// each merge with L live slots runs one slot RAM read, one node RAM read
// and one compare per slot through the shared two-minimum unit, followed by
// write-back and swap (S_MERGE, S_SWAP_RD, S_SWAP_WB, S_SWAP_WL). The
// depth-first walk fetches and pushes the root, then pops each node through
// S_POP, S_POP_RN and S_VISIT, with one S_PUSH_L per left child pushed and
// one S_EMIT per output transaction, held by output backpressure. Overall
// the run is quadratic in n, bounded by the single read ports of the RAMs.
// ============================================================================
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [hcb_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hcb_pkg::FREQ_W-1:0]   i_frequency,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [hcb_pkg::SYM_W-1:0]    o_leaf_symbol,
    output logic [hcb_pkg::LEN_W-1:0]    o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]   o_code_bits,
    output logic                         o_overflowed,
    output logic                         o_final_code
);

    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int NW     = $clog2(NODES);
    localparam int SW     = $clog2(MAX_SYMBOLS);
    localparam int CW     = $clog2(MAX_SYMBOLS + 1);
    localparam int WW     = hcb_pkg::WEIGHT_W;
    localparam int SYW    = hcb_pkg::SYM_W;
    localparam int LW     = hcb_pkg::LEN_W;
    localparam int CDW    = hcb_pkg::CODE_W;
    // node word: {weight, left, right, leaf flag, symbol}
    localparam int NODE_DW = WW + 2 * NW + 1 + SYW;
    localparam int LEAF_B  = SYW;
    localparam int RIGHT_L = SYW + 1;
    localparam int LEFT_L  = SYW + 1 + NW;
    localparam int WGT_L   = SYW + 1 + 2 * NW;
    // stack word: {node, depth, code}
    localparam int STK_DW  = NW + LW + CDW;

    typedef enum logic [15:0] {
        S_LOAD      = 16'h0001,
        S_INIT      = 16'h0002,
        S_SCAN_RS   = 16'h0004,
        S_SCAN_RN   = 16'h0008,
        S_SCAN_CMP  = 16'h0010,
        S_MERGE     = 16'h0020,
        S_SWAP_RD   = 16'h0040,
        S_SWAP_WB   = 16'h0080,
        S_SWAP_WL   = 16'h0100,
        S_ROOT_RD   = 16'h0200,
        S_ROOT_PUSH = 16'h0400,
        S_POP       = 16'h0800,
        S_POP_RN    = 16'h1000,
        S_VISIT     = 16'h2000,
        S_PUSH_L    = 16'h4000,
        S_EMIT      = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]  r_count, n_count;   // leaves held
    logic           r_ovf, n_ovf;
    logic [CW-1:0]  r_i, n_i;           // slot counter
    logic [CW-1:0]  r_live, n_live;
    logic [NW-1:0]  r_next, n_next;
    logic [CW-1:0]  r_sp, n_sp;
    logic [NW-1:0]  r_nd, n_nd;
    logic [LW-1:0]  r_d, n_d;
    logic [CDW-1:0] r_c, n_c;
    logic [NW-1:0]  r_left, n_left;

    // output register
    logic           r_ovalid, n_ovalid;
    logic [SYW-1:0] r_osym, n_osym;
    logic [LW-1:0]  r_olen, n_olen;
    logic [CDW-1:0] r_ocode, n_ocode;
    logic           r_oovf, n_oovf;
    logic           r_ofinal, n_ofinal;

    // RAM ports
    logic               node_we, slot_we, stk_we;
    logic [NW-1:0]      node_waddr, node_raddr;
    logic [NODE_DW-1:0] node_wdata, node_rdata;
    logic [SW-1:0]      slot_waddr, slot_raddr;
    logic [NW-1:0]      slot_wdata, slot_rdata;
    logic [SW-1:0]      stk_waddr, stk_raddr;
    logic [STK_DW-1:0]  stk_wdata, stk_rdata;

    // scan unit
    logic           scan_step;
    logic [SW-1:0]  pick_sa, pick_sb;
    logic [NW-1:0]  pick_na, pick_nb;
    logic [WW-1:0]  pick_sum;

    logic           in_fire;
    logic [CW-1:0]  live_m1;

    assign in_fire = i_in_valid && o_in_ready;
    assign live_m1 = r_live - CW'(1);

    hcb_ram #(.WIDTH(NODE_DW), .DEPTH(NODES)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    hcb_ram #(.WIDTH(NW), .DEPTH(MAX_SYMBOLS)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    hcb_ram #(.WIDTH(STK_DW), .DEPTH(MAX_SYMBOLS)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    hcb_scan_unit #(.SW(SW), .NW(NW)) u_scan (
        .i_clk(i_clk), .i_step(scan_step), .i_pos(r_i[SW-1:0]), .i_node(r_nd),
        .i_weight(node_rdata[WGT_L +: WW]),
        .o_slot_a(pick_sa), .o_slot_b(pick_sb), .o_node_a(pick_na),
        .o_node_b(pick_nb), .o_weight_sum(pick_sum)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_i      = r_i;
        n_live   = r_live;
        n_next   = r_next;
        n_sp     = r_sp;
        n_nd     = r_nd;
        n_d      = r_d;
        n_c      = r_c;
        n_left   = r_left;
        n_ovalid = r_ovalid;
        n_osym   = r_osym;
        n_olen   = r_olen;
        n_ocode  = r_ocode;
        n_oovf   = r_oovf;
        n_ofinal = r_ofinal;

        node_we    = 1'b0;
        node_waddr = r_count[NW-1:0];
        node_wdata = {WW'(i_frequency), {NW{1'b0}}, {NW{1'b0}}, 1'b1, i_symbol};
        node_raddr = slot_rdata;
        slot_we    = 1'b0;
        slot_waddr = r_i[SW-1:0];
        slot_wdata = NW'(r_i);
        slot_raddr = r_i[SW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_sp[SW-1:0];
        stk_wdata  = {node_rdata[RIGHT_L +: NW], r_d + LW'(1), r_c[CDW-2:0], 1'b1};
        stk_raddr  = r_sp[SW-1:0];
        scan_step  = 1'b0;
        o_in_ready = 1'b0;

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (r_count < CW'(MAX_SYMBOLS)) begin
                        node_we = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // identity slot list
                slot_we = 1'b1;
                n_i     = r_i + CW'(1);
                if (r_i == r_count - CW'(1)) begin
                    n_live = r_count;
                    n_next = NW'(r_count);
                    n_i    = '0;
                    n_state = (r_count > CW'(1)) ? S_SCAN_RS : S_ROOT_RD;
                end
            end
            S_SCAN_RS: begin
                n_state = S_SCAN_RN;
            end
            S_SCAN_RN: begin
                n_nd    = slot_rdata;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                scan_step = 1'b1;
                n_i       = r_i + CW'(1);
                if (r_i == live_m1) begin
                    n_state = S_MERGE;
                end else begin
                    n_state = S_SCAN_RS;
                end
            end
            S_MERGE: begin
                node_we    = 1'b1;
                node_waddr = r_next;
                node_wdata = {pick_sum, pick_na, pick_nb, 1'b0, {SYW{1'b0}}};
                slot_we    = 1'b1;
                slot_waddr = pick_sa;
                slot_wdata = r_next;
                n_state    = S_SWAP_RD;
            end
            S_SWAP_RD: begin
                slot_raddr = live_m1[SW-1:0];
                n_state    = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                slot_we    = 1'b1;
                slot_waddr = pick_sb;
                slot_wdata = slot_rdata;
                n_state    = S_SWAP_WL;
            end
            S_SWAP_WL: begin
                slot_we    = 1'b1;
                slot_waddr = live_m1[SW-1:0];
                slot_wdata = pick_nb;
                n_live     = live_m1;
                n_next     = r_next + NW'(1);
                n_i        = '0;
                n_state    = (live_m1 > CW'(1)) ? S_SCAN_RS : S_ROOT_RD;
            end
            S_ROOT_RD: begin
                slot_raddr = '0;
                n_state    = S_ROOT_PUSH;
            end
            S_ROOT_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {slot_rdata, {LW{1'b0}}, {CDW{1'b0}}};
                n_sp      = CW'(1);
                n_state   = S_POP;
            end
            S_POP: begin
                n_sp      = r_sp - CW'(1);
                stk_raddr = n_sp[SW-1:0];
                n_state   = S_POP_RN;
            end
            S_POP_RN: begin
                node_raddr = stk_rdata[LW+CDW +: NW];
                n_nd       = stk_rdata[LW+CDW +: NW];
                n_d        = stk_rdata[CDW +: LW];
                n_c        = stk_rdata[CDW-1:0];
                n_state    = S_VISIT;
            end
            S_VISIT: begin
                if (node_rdata[LEAF_B]) begin
                    n_ovalid = 1'b1;
                    n_osym   = node_rdata[SYW-1:0];
                    n_olen   = r_d;
                    n_ocode  = r_c;
                    n_oovf   = r_ovf;
                    n_ofinal = (r_sp == '0);
                    n_state  = S_EMIT;
                end else begin
                    // right first so left pops first
                    stk_we  = 1'b1;
                    n_left  = node_rdata[LEFT_L +: NW];
                    n_sp    = r_sp + CW'(1);
                    n_state = S_PUSH_L;
                end
            end
            S_PUSH_L: begin
                stk_we    = 1'b1;
                stk_wdata = {r_left, r_d + LW'(1), r_c[CDW-2:0], 1'b0};
                n_sp      = r_sp + CW'(1);
                n_state   = S_POP;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    if (r_ofinal) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_live   <= n_live;
        r_next   <= n_next;
        r_sp     <= n_sp;
        r_nd     <= n_nd;
        r_d      <= n_d;
        r_c      <= n_c;
        r_left   <= n_left;
        r_osym   <= n_osym;
        r_olen   <= n_olen;
        r_ocode  <= n_ocode;
        r_oovf   <= n_oovf;
        r_ofinal <= n_ofinal;
    end

    assign o_out_valid   = r_ovalid;
    assign o_leaf_symbol = r_osym;
    assign o_code_length = r_olen;
    assign o_code_bits   = r_ocode;
    assign o_overflowed  = r_oovf;
    assign o_final_code  = r_ofinal;

endmodule

### sv/hcb_checker.sv
// ============================================================================
// hcb_checker: port-level checks for the Huffman code builder
// Watches the top-level ports over time; bound to every instance.
// ============================================================================
module hcb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_code_length,
    input logic [14:0] o_code_bits,
    input logic       o_final_code
);

    // a stalled output transaction holds its code bits and final flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_bits)
            && $stable(o_final_code))
        else $error("output transaction changed while stalled");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    // the last symbol closes the input until the run is emitted
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready)
        else $error("input ready right after last symbol");

    // the final code returns the block to loading
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_final_code |=> o_in_ready && !o_out_valid)
        else $error("block not back to loading after final code");

    // a zero-length code carries no bits
    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_code_length == 4'd0) |-> (o_code_bits == 15'd0))
        else $error("zero-length code with bits set");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .i_last(i_last), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_code_length(o_code_length),
    .o_code_bits(o_code_bits), .o_final_code(o_final_code)
);
